// ===== hdl/cfl_pkg.sv =====
// Shared types, constants and codes for the CFL timestep reduction block.
`timescale 1ns / 1ps
package cfl_pkg;

    // Number of momentum components used by default
    localparam int DIMENSIONS_DEF = 3;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Saturation limits
    localparam logic [46:0] CAP    = '1;
    localparam logic [30:0] TS_MAX = '1;

    // Register indexes
    localparam logic [1:0] REG_GAMMA = 2'd0;
    localparam logic [1:0] REG_DX    = 2'd1;
    localparam logic [1:0] REG_CFL   = 2'd2;

    // Register reset values
    localparam logic [17:0] GAMMA_RST = 18'd91750;
    localparam logic [30:0] DX_RST    = 31'd65536;
    localparam logic [16:0] CFL_RST   = 17'd52429;

    // Arithmetic unit operation codes
    localparam logic [1:0] OP_MUL  = 2'd0;
    localparam logic [1:0] OP_DIV  = 2'd1;
    localparam logic [1:0] OP_SQRT = 2'd2;

    // Classified cell fields carried through the queue
    typedef struct packed {
        logic              last;
        logic signed [31:0] energy;
        logic [30:0]       dens;
    } cell_t;

    // Request to the shared arithmetic unit
    typedef struct packed {
        logic        start;
        logic [1:0]  op;
        logic [63:0] a;
        logic [47:0] b;
    } arith_req_t;

    // Response from the shared arithmetic unit
    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } arith_rsp_t;

    // Configuration write
    typedef struct packed {
        logic        valid;
        logic [1:0]  index;
        logic [30:0] data;
    } cfg_wr_t;

endpackage

// ===== hdl/cfl_front.sv =====
// Front end: accepts cells, floors density and takes momentum magnitudes.
`timescale 1ns / 1ps
module cfl_front
    import cfl_pkg::*;
#(
    parameter int DIMENSIONS = DIMENSIONS_DEF,
    parameter int ENTRY_W    = $bits(cell_t) + 32 * DIMENSIONS
)
(
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [159:0]       s_tdata,
    input  logic               s_tlast,
    input  logic               full,
    output logic               push,
    output logic [ENTRY_W-1:0] push_data
);

    cell_t              fields;
    logic signed [31:0] dens_s;
    logic [31:0]        mom_abs [DIMENSIONS];

    // Density floored at one LSB
    always_comb
    begin
        dens_s        = $signed(s_tdata[31:0]);
        fields.last   = s_tlast;
        fields.energy = $signed(s_tdata[159:128]);
        if (dens_s[31] || (dens_s == 32'sd0))
        begin
            fields.dens = 31'd1;
        end
        else
        begin
            fields.dens = dens_s[30:0];
        end
    end

    // Momentum magnitudes of the used components
    for (genvar k = 0; k < DIMENSIONS; k++)
    begin : g_mom
        logic [31:0] m;
        assign m          = s_tdata[32*(k+1) +: 32];
        assign mom_abs[k] = m[31] ? (~m + 32'd1) : m;
        assign push_data[$bits(cell_t) + 32*k +: 32] = mom_abs[k];
    end

    assign push_data[$bits(cell_t)-1:0] = fields;

    // Transfer into the queue
    assign s_tready = !full;
    assign push     = s_tvalid && !full;

endmodule

// ===== hdl/cfl_queue.sv =====
// Small queue between front and back, registered read on pop.
`timescale 1ns / 1ps
module cfl_queue
    import cfl_pkg::*;
#(
    parameter int W     = 32,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic [W-1:0] rd_data,
    output logic         full,
    output logic         empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [W-1:0]     rd_data_reg;

    // Pointer advance with wrap
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1))
            return '0;
        return p + 1'b1;
    endfunction

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
        if (pop)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/cfl_arith.sv =====
// Shared radix-2 arithmetic unit: Q16.16 multiply, divide, integer square root.
`timescale 1ns / 1ps
module cfl_arith
    import cfl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  arith_req_t req,
    output arith_rsp_t rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic [1:0]  op_reg;
    logic [5:0]  cnt_reg;
    logic [47:0] a_reg;
    logic [47:0] b_reg;
    // multiply: product and multiplier
    logic [95:0] prod_reg;
    // divide: dividend shifter, remainder, quotient
    logic [63:0] num_reg;
    logic [47:0] rem_reg;
    logic [63:0] quo_reg;
    // square root: radicand shifter, remainder, root
    logic [63:0] rad_reg;
    logic [33:0] srem_reg;
    logic [31:0] root_reg;

    logic [48:0] mul_sum;
    logic [48:0] div_sh;
    logic [35:0] sq_sh;
    logic [35:0] sq_trial;

    // Step datapaths
    always_comb
    begin
        mul_sum  = {1'b0, prod_reg[95:48]} + {1'b0, a_reg};
        div_sh   = {rem_reg, num_reg[63]};
        sq_sh    = {srem_reg, rad_reg[63:62]};
        sq_trial = {2'b00, root_reg, 2'b01};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                unique case (req.op)
                    OP_MUL:  cnt_reg <= 6'd47;
                    OP_DIV:  cnt_reg <= 6'd63;
                    default: cnt_reg <= 6'd31;
                endcase
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand load and iteration
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg    <= req.a[47:0];
            b_reg    <= req.b;
            prod_reg <= {48'd0, req.b};
            num_reg  <= req.a;
            rem_reg  <= '0;
            quo_reg  <= '0;
            rad_reg  <= req.a;
            srem_reg <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                OP_MUL:
                begin
                    if (prod_reg[0])
                        prod_reg <= {mul_sum, prod_reg[47:1]};
                    else
                        prod_reg <= {1'b0, prod_reg[95:1]};
                end
                OP_DIV:
                begin
                    num_reg <= {num_reg[62:0], 1'b0};
                    if (div_sh >= {1'b0, b_reg})
                    begin
                        rem_reg <= 48'(div_sh - {1'b0, b_reg});
                        quo_reg <= {quo_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= div_sh[47:0];
                        quo_reg <= {quo_reg[62:0], 1'b0};
                    end
                end
                default:
                begin
                    rad_reg <= {rad_reg[61:0], 2'b00};
                    if (sq_sh >= sq_trial)
                    begin
                        srem_reg <= 34'(sq_sh - sq_trial);
                        root_reg <= {root_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        srem_reg <= sq_sh[33:0];
                        root_reg <= {root_reg[30:0], 1'b0};
                    end
                end
            endcase
        end
    end

    // Result select; the product is shifted by 16 and saturated
    always_comb
    begin
        rsp.done = done_reg;
        unique case (op_reg)
            OP_MUL:
            begin
                if (|prod_reg[95:63])
                    rsp.res = {17'd0, CAP};
                else
                    rsp.res = {17'd0, prod_reg[62:16]};
            end
            OP_DIV:  rsp.res = quo_reg;
            default: rsp.res = {32'd0, root_reg};
        endcase
    end

endmodule

// ===== hdl/cfl_back.sv =====
// Back end: per-cell timestep sequencer, running minimum, result register.
`timescale 1ns / 1ps
module cfl_back
    import cfl_pkg::*;
#(
    parameter int DIMENSIONS = DIMENSIONS_DEF,
    parameter int ENTRY_W    = $bits(cell_t) + 32 * DIMENSIONS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_wr_t            cfg,
    input  logic               empty,
    output logic               pop,
    input  logic [ENTRY_W-1:0] rd_data,
    output arith_req_t         req,
    input  arith_rsp_t         rsp,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata
);

    localparam int KW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_VDIV  = 4'd2;
    localparam logic [3:0] S_VSQ   = 4'd3;
    localparam logic [3:0] S_EKIN  = 4'd4;
    localparam logic [3:0] S_P     = 4'd5;
    localparam logic [3:0] S_GP    = 4'd6;
    localparam logic [3:0] S_RATIO = 4'd7;
    localparam logic [3:0] S_SQRT  = 4'd8;
    localparam logic [3:0] S_NUM   = 4'd9;
    localparam logic [3:0] S_DT    = 4'd10;
    localparam logic [3:0] S_EMIT  = 4'd11;

    logic [3:0]  state_reg, state_next;
    cell_t       cell_reg, cell_next;
    logic [31:0] mom_reg [DIMENSIONS];
    logic [31:0] mom_next [DIMENSIONS];
    logic [KW-1:0] k_reg, k_next;
    logic [46:0] vmax_reg, vmax_next;
    logic [46:0] vel2_reg, vel2_next;
    logic [46:0] val_reg, val_next;
    logic [31:0] cs_reg, cs_next;
    logic [30:0] dt_reg, dt_next;
    logic [30:0] runmin_reg, runmin_next;
    logic        out_valid_reg, out_valid_next;
    logic [30:0] out_data_reg, out_data_next;
    logic [17:0] gamma_reg;
    logic [30:0] dx_reg;
    logic [16:0] cfl_reg;

    cell_t              rd_cell;
    logic [46:0]        res_sat;
    logic [47:0]        vel2_sum;
    logic [45:0]        ekin;
    logic signed [48:0] eint;
    logic [48:0]        emag_full;
    logic signed [18:0] g1;
    logic [18:0]        gmag_full;
    logic [14:0]        pfloor;
    logic [46:0]        p_val;
    logic [47:0]        denom;
    logic [30:0]        dt_val;

    assign rd_cell = rd_data[$bits(cell_t)-1:0];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg <= GAMMA_RST;
            dx_reg    <= DX_RST;
            cfl_reg   <= CFL_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_GAMMA: gamma_reg <= cfg.data[17:0];
                REG_DX:    dx_reg    <= cfg.data;
                REG_CFL:   cfl_reg   <= cfg.data[16:0];
                default:   ;
            endcase
        end
    end

    // Derived values from the arithmetic result and held cell
    always_comb
    begin
        res_sat   = (|rsp.res[63:47]) ? CAP : rsp.res[46:0];
        vel2_sum  = {1'b0, vel2_reg} + {1'b0, rsp.res[46:0]};
        ekin      = rsp.res[46:1];
        eint      = $signed({{17{cell_reg.energy[31]}}, cell_reg.energy})
                    - $signed({3'b000, ekin});
        emag_full = eint[48] ? 49'(-eint) : 49'(eint);
        g1        = $signed({1'b0, gamma_reg}) - 19'sd65536;
        gmag_full = g1[18] ? 19'(-g1) : 19'(g1);
        pfloor    = cell_reg.dens[30:16];
        p_val     = (rsp.res[46:0] < {32'd0, pfloor}) ? {32'd0, pfloor} : rsp.res[46:0];
        denom     = {1'b0, vmax_reg} + {16'd0, cs_reg};
        dt_val    = (|rsp.res[63:31]) ? TS_MAX : rsp.res[30:0];
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cell_next      = cell_reg;
        mom_next       = mom_reg;
        k_next         = k_reg;
        vmax_next      = vmax_reg;
        vel2_next      = vel2_reg;
        val_next       = val_reg;
        cs_next        = cs_reg;
        dt_next        = dt_reg;
        runmin_next    = runmin_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        req            = '0;

        // result register drains independently
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cell_next = rd_cell;
                for (int k = 0; k < DIMENSIONS; k++)
                begin
                    mom_next[k] = rd_data[$bits(cell_t) + 32*k +: 32];
                end
                k_next     = '0;
                vmax_next  = '0;
                vel2_next  = '0;
                req.start  = 1'b1;
                req.op     = OP_DIV;
                req.a      = {16'd0, rd_data[$bits(cell_t) +: 32], 16'd0};
                req.b      = {17'd0, rd_cell.dens};
                state_next = S_VDIV;
            end
            S_VDIV:
            begin
                if (rsp.done)
                begin
                    if (res_sat > vmax_reg)
                        vmax_next = res_sat;
                    req.start  = 1'b1;
                    req.op     = OP_MUL;
                    req.a      = {17'd0, res_sat};
                    req.b      = {1'b0, res_sat};
                    state_next = S_VSQ;
                end
            end
            S_VSQ:
            begin
                if (rsp.done)
                begin
                    vel2_next = vel2_sum[47] ? CAP : vel2_sum[46:0];
                    req.start = 1'b1;
                    if (k_reg == KW'(DIMENSIONS - 1))
                    begin
                        req.op     = OP_MUL;
                        req.a      = {33'd0, cell_reg.dens};
                        req.b      = {1'b0, vel2_next};
                        state_next = S_EKIN;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        req.op     = OP_DIV;
                        req.a      = {16'd0, mom_reg[k_next], 16'd0};
                        req.b      = {17'd0, cell_reg.dens};
                        state_next = S_VDIV;
                    end
                end
            end
            S_EKIN:
            begin
                if (rsp.done)
                begin
                    req.start = 1'b1;
                    req.op    = OP_MUL;
                    if (eint[48] != g1[18])
                    begin
                        // opposite signs: pressure is the floor
                        val_next   = {32'd0, pfloor};
                        req.a      = {46'd0, gamma_reg};
                        req.b      = {33'd0, pfloor};
                        state_next = S_GP;
                    end
                    else
                    begin
                        req.a      = {17'd0, emag_full[46:0]};
                        req.b      = {30'd0, gmag_full[17:0]};
                        state_next = S_P;
                    end
                end
            end
            S_P:
            begin
                if (rsp.done)
                begin
                    val_next   = p_val;
                    req.start  = 1'b1;
                    req.op     = OP_MUL;
                    req.a      = {46'd0, gamma_reg};
                    req.b      = {1'b0, p_val};
                    state_next = S_GP;
                end
            end
            S_GP:
            begin
                if (rsp.done)
                begin
                    req.start  = 1'b1;
                    req.op     = OP_DIV;
                    req.a      = {1'b0, rsp.res[46:0], 16'd0};
                    req.b      = {17'd0, cell_reg.dens};
                    state_next = S_RATIO;
                end
            end
            S_RATIO:
            begin
                if (rsp.done)
                begin
                    val_next   = res_sat;
                    req.start  = 1'b1;
                    req.op     = OP_SQRT;
                    req.a      = {1'b0, res_sat, 16'd0};
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (rsp.done)
                begin
                    cs_next    = rsp.res[31:0];
                    req.start  = 1'b1;
                    req.op     = OP_MUL;
                    req.a      = {47'd0, cfl_reg};
                    req.b      = {17'd0, dx_reg};
                    state_next = S_NUM;
                end
            end
            S_NUM:
            begin
                if (rsp.done)
                begin
                    req.start  = 1'b1;
                    req.op     = OP_DIV;
                    req.a      = {16'd0, rsp.res[31:0], 16'd0};
                    req.b      = (denom == '0) ? 48'd1 : denom;
                    state_next = S_DT;
                end
            end
            S_DT:
            begin
                if (rsp.done)
                begin
                    dt_next = (dt_val < runmin_reg) ? dt_val : runmin_reg;
                    if (cell_reg.last)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        runmin_next = dt_next;
                        state_next  = S_IDLE;
                    end
                end
            end
            S_EMIT:
            begin
                // last cell of the batch: load an empty result register
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = dt_reg;
                    runmin_next    = TS_MAX;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            runmin_reg    <= TS_MAX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            runmin_reg    <= runmin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        cell_reg     <= cell_next;
        mom_reg      <= mom_next;
        k_reg        <= k_next;
        vmax_reg     <= vmax_next;
        vel2_reg     <= vel2_next;
        val_reg      <= val_next;
        cs_reg       <= cs_next;
        dt_reg       <= dt_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg};

endmodule

// ===== hdl/cfl_timestep_min_reduction.sv =====
// Top level of the CFL timestep minimum reduction block.
//
// Each cell on the input stream yields a Courant timestep courant*dx/(vmax+cs);
// the smallest over a batch goes out as one result when the cell marked by
// tlast has been processed, and the minimum then restarts. Cells are worked
// one at a time by a sequencer around a single shared radix-2 unit (48-, 64- and
// 32-step multiply, divide and square root), and the pressure multiply is skipped
// when opposite signs put the pressure at its floor. A two-entry queue lets the
// input side take up to two cells ahead of the sequencer, and the result register
// holds a batch minimum until it is taken. Configuration writes are taken every
// cycle and should only be issued while the block is idle.
`timescale 1ns / 1ps
module cfl_timestep_min_reduction
    import cfl_pkg::*;
#(
    parameter int DIMENSIONS = DIMENSIONS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    // input cells
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,   // density, momentum_x, momentum_y, momentum_z, total_energy
    input  logic         s_tlast,   // last_cell
    // batch results
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // min_timestep (31 bits), one zero pad bit
    // configuration writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [30:0]  cfg_data
);

    localparam int ENTRY_W = $bits(cell_t) + 32 * DIMENSIONS;

    logic               push, pop, full, empty;
    logic [ENTRY_W-1:0] push_data, rd_data;
    arith_req_t         req;
    arith_rsp_t         rsp;
    cfg_wr_t            cfg;

    assign cfg_ready = 1'b1;
    assign cfg.valid = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    cfl_front #(.DIMENSIONS(DIMENSIONS), .ENTRY_W(ENTRY_W)) u_front
    (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    cfl_queue #(.W(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .rd_data   (rd_data),
        .full      (full),
        .empty     (empty)
    );

    cfl_arith u_arith
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    cfl_back #(.DIMENSIONS(DIMENSIONS), .ENTRY_W(ENTRY_W)) u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .empty    (empty),
        .pop      (pop),
        .rd_data  (rd_data),
        .req      (req),
        .rsp      (rsp),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== hdl/cfl_checker.sv =====
// Port-level checks for the CFL timestep reduction block, bound to the top level.
`timescale 1ns / 1ps
module cfl_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // A stalled result holds its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A timestep never exceeds the saturation limit
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[31])
        else $error("result above saturation limit");

    // The result register is loaded only while empty, so no result follows a transfer at once
    a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |=> !m_tvalid)
        else $error("result right after a transfer");

endmodule

bind cfl_timestep_min_reduction cfl_checker u_cfl_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== verif/tb_cfl_timestep_min_reduction.sv =====
// Testbench for the CFL timestep minimum reduction block: random cells and batch minimum checks.
`timescale 1ns / 1ps
module tb_cfl_timestep_min_reduction;
    import cfl_pkg::*;

    localparam int        DIMS         = DIMENSIONS_DEF;
    localparam int        IDLE_LIMIT   = 200000;
    localparam int        DRAIN_CYCLES = 3000;
    localparam int        HOLDOFF      = 20000;
    localparam int        RAND_ITEMS   = 1230;
    localparam int        PHASES       = 8;
    localparam bit [63:0] SAT          = 64'h0000_7FFF_FFFF_FFFF;

    // Tracks register values and running minimum; holds predicted batch minima
    class timestep_tracker;
        bit [17:0] gamma;
        bit [30:0] dx;
        bit [16:0] courant;
        bit [30:0] run_min;
        bit [30:0] expected_minima[$];
        int        errors;

        function new();
            gamma   = GAMMA_RST;
            dx      = DX_RST;
            courant = CFL_RST;
            run_min = TS_MAX;
            errors  = 0;
        endfunction

        function void set_reg(bit [1:0] idx, bit [30:0] val);
            if (idx == REG_GAMMA)
                gamma = val[17:0];
            else if (idx == REG_DX)
                dx = val;
            else if (idx == REG_CFL)
                courant = val[16:0];
        endfunction

        // Q16.16 product, truncated, saturated
        function bit [63:0] fx_mul(bit [63:0] a, bit [63:0] b);
            bit [127:0] pr;
            pr = {64'd0, a} * {64'd0, b};
            pr = pr >> 16;
            return (pr > {64'd0, SAT}) ? SAT : pr[63:0];
        endfunction

        // Q16.16 quotient, a <= SAT, b >= 1
        function bit [63:0] fx_div(bit [63:0] a, bit [63:0] b);
            bit [63:0] r;
            r = (a << 16) / b;
            return (r > SAT) ? SAT : r;
        endfunction

        function bit [63:0] int_sqrt(bit [63:0] x);
            bit [63:0] res;
            bit [63:0] bt;
            res = 0;
            bt  = 64'd1 << 62;
            while (bt > x)
                bt = bt >> 2;
            while (bt != 0)
            begin
                if (x >= res + bt)
                begin
                    x   = x - (res + bt);
                    res = (res >> 1) + bt;
                end
                else
                    res = res >> 1;
                bt = bt >> 2;
            end
            return res;
        endfunction

        function bit [30:0] cell_timestep(bit [159:0] cell_bits);
            longint    ds, m, eint, g1;
            bit [63:0] d, mm, v, vmax, vel2, ekin, pfloor, p, gp, ratio, cs;
            bit [63:0] denom, num, dt, emag, gmag;
            ds   = longint'($signed(cell_bits[31:0]));
            d    = (ds < 1) ? 64'd1 : 64'(ds);
            vmax = 0;
            vel2 = 0;
            for (int k = 0; k < DIMS && k < 3; k++)
            begin
                m  = longint'($signed(cell_bits[32*(k+1) +: 32]));
                mm = (m < 0) ? 64'(-m) : 64'(m);
                v  = fx_div(mm, d);
                if (v > vmax)
                    vmax = v;
                vel2 = vel2 + fx_mul(v, v);
                if (vel2 > SAT)
                    vel2 = SAT;
            end
            ekin   = fx_mul(d, vel2) >> 1;
            eint   = longint'($signed(cell_bits[159:128])) - longint'(ekin);
            g1     = longint'(gamma) - 65536;
            pfloor = d >> 16;
            emag   = (eint < 0) ? 64'(-eint) : 64'(eint);
            gmag   = (g1 < 0) ? 64'(-g1) : 64'(g1);
            // opposite signs give a negative pressure: use the floor
            if ((eint < 0) != (g1 < 0))
                p = pfloor;
            else
            begin
                p = fx_mul(emag, gmag);
                if (p < pfloor)
                    p = pfloor;
            end
            gp    = fx_mul({46'd0, gamma}, p);
            ratio = fx_div(gp, d);
            cs    = int_sqrt(ratio << 16);
            denom = vmax + cs;
            if (denom < 1)
                denom = 1;
            num = fx_mul({47'd0, courant}, {33'd0, dx});
            dt  = (num << 16) / denom;
            if (dt > 64'(TS_MAX))
                dt = 64'(TS_MAX);
            return dt[30:0];
        endfunction

        function void note_cell(bit [159:0] cell_bits, bit last);
            bit [30:0] dt;
            dt = cell_timestep(cell_bits);
            if (dt < run_min)
                run_min = dt;
            if (last)
            begin
                expected_minima = {expected_minima, run_min};
                run_min = TS_MAX;
            end
        endfunction

        function void check_min(bit [30:0] got);
            bit [30:0] want;
            if (expected_minima.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            want = expected_minima.pop_front();
            if (got !== want)
            begin
                errors++;
                $display("%0t: min_timestep mismatch, expected %h, actual %h", $time, want, got);
            end
        endfunction
    endclass

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [159:0] s_tdata   = '0;
    logic         s_tlast   = 1'b0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [31:0]  m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [30:0]  cfg_data  = '0;

    timestep_tracker tracker = new();
    int  results_seen  = 0;
    int  idle_cycles   = 0;
    bit  burst_mode    = 1'b0;

    cfl_timestep_min_reduction dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #1 clk = ~clk;

    // Mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 4);
        else
            return $urandom_range(20, 300);
    endfunction

    // One register write; the channel idles after each transfer
    task automatic write_reg(bit [1:0] idx, bit [30:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.set_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_cell(bit [159:0] cell_bits, bit last);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= cell_bits;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        tracker.note_cell(cell_bits, last);
        gap = burst_mode ? 0 : gap_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Wait for all batch results, then let the pipeline settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (tracker.expected_minima.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic bit [159:0] make_cell();
        bit [159:0] c;
        int         sh;
        if ($urandom_range(0, 4) == 0)
            return {$urandom, $urandom, $urandom, $urandom, $urandom};
        // physically plausible cell with random scale
        sh = $urandom_range(0, 6);
        c[31:0] = 32'($urandom_range(1 << 10, 1 << 24)) << sh;
        for (int k = 1; k < 4; k++)
        begin
            c[32*k +: 32] = 32'($urandom_range(0, 1 << 22)) << sh;
            if ($urandom_range(0, 1))
                c[32*k +: 32] = -c[32*k +: 32];
        end
        c[159:128] = 32'($urandom_range(0, 1 << 26)) << sh;
        if ($urandom_range(0, 9) == 0)
            c[159:128] = -c[159:128];
        return c;
    endfunction

    // Receiver: random backpressure plus one long hold-off
    initial
    begin
        int  stall;
        bit  held;
        held = 1'b0;
        m_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                tracker.check_min(m_tdata[30:0]);
                results_seen++;
            end
            if (!held && results_seen == 20)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLDOFF) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                stall = burst_mode ? 0 : gap_len();
                if (stall > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no transfer anywhere
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        int left;
        int blen;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed cells under reset configuration
        send_cell({32'd65536, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b1);
        send_cell({32'h0001_0000, 32'd0, 32'd0, 32'd0, 32'h8000_0000}, 1'b1);
        send_cell({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF}, 1'b1);
        send_cell({32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000}, 1'b1);
        send_cell({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF}, 1'b0);
        send_cell({32'h7FFF_FFFF, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'd1}, 1'b1);
        send_cell({32'h0010_0000, 32'h0003_0000, 32'hFFFD_0000, 32'h0001_0000,
                   32'h0020_0000}, 1'b0);
        send_cell({32'h0100_0000, 32'h0000_0001, 32'd0, 32'd0, 32'h0040_0000}, 1'b0);
        send_cell({32'h0000_8000, 32'h0000_0100, 32'd0, 32'd0, 32'd100}, 1'b1);
        send_cell({32'd0, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b1);
        wait_drained();

        // high extremes, plus a write to an unused index
        write_reg(REG_GAMMA, 31'd65537);
        write_reg(REG_DX, 31'h7FFF_FFFF);
        write_reg(REG_CFL, 31'd65536);
        write_reg(2'd3, 31'h7FFF_FFFF);
        send_cell({32'h0001_0000, 32'd0, 32'd0, 32'd0, 32'h0001_0000}, 1'b1);
        send_cell({32'd1, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b1);
        send_cell({32'h0002_0000, 32'h0001_0000, 32'd0, 32'd0, 32'h0010_0000}, 1'b1);
        wait_drained();

        // gamma below one, zero dx and Courant number
        write_reg(REG_GAMMA, 31'd0);
        write_reg(REG_DX, 31'd0);
        write_reg(REG_CFL, 31'd0);
        send_cell({32'h0001_0000, 32'd0, 32'd0, 32'd0, 32'h0001_0000}, 1'b1);
        send_cell({32'h0001_0000, 32'd0, 32'd0, 32'd0, 32'h8000_0000}, 1'b1);
        wait_drained();

        // random phases; the first two at the extremes, the third at reset values
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(REG_GAMMA, 31'd196608);
                    write_reg(REG_DX, 31'd1);
                    write_reg(REG_CFL, 31'd1);
                end
                1:
                begin
                    write_reg(REG_GAMMA, 31'h7FFF_FFFF);
                    write_reg(REG_DX, 31'h4000_0000);
                    write_reg(REG_CFL, 31'h7FFF_FFFF);
                end
                2:
                begin
                    write_reg(REG_GAMMA, 31'(GAMMA_RST));
                    write_reg(REG_DX, DX_RST);
                    write_reg(REG_CFL, 31'(CFL_RST));
                end
                default:
                begin
                    write_reg(REG_GAMMA, 31'($urandom_range(65537, 196608)));
                    write_reg(REG_DX, 31'($urandom_range(1, 32'h7FFF_FFFF)));
                    write_reg(REG_CFL, 31'($urandom_range(1, 65536)));
                end
            endcase
            burst_mode = (ph == 4);
            left = RAND_ITEMS / PHASES;
            while (left > 0)
            begin
                blen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30)
                                                   : $urandom_range(1, 8);
                if (blen > left)
                    blen = left;
                for (int i = 0; i < blen; i++)
                    send_cell(make_cell(), i == blen - 1);
                left = left - blen;
            end
            wait_drained();
            burst_mode = 1'b0;
        end

        if (tracker.expected_minima.size() != 0)
            tracker.errors++;
        if (tracker.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/cfl_pkg.sv
hdl/cfl_front.sv
hdl/cfl_queue.sv
hdl/cfl_arith.sv
hdl/cfl_back.sv
hdl/cfl_timestep_min_reduction.sv
hdl/cfl_checker.sv
verif/tb_cfl_timestep_min_reduction.sv
